// ----- hdl/bitmap_block_allocator_assert.svh -----
// Assertion macros for the block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

`define BBA_ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

`define BBA_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ----- hdl/bba_pkg.sv -----
`timescale 1ns / 1ps
package bba_pkg;
  localparam int NBLK = 256;
  localparam int IW = 8;
  localparam int CW = 9;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;

  typedef struct packed {
    logic [0:0] kind;
    logic [8:0] run_length;
    logic [7:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] start_block;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request, clear scan state
    logic step;     // examine one block at scan index
    logic commit;   // write one block of the chosen run
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free_op;
    logic bad_size;
    logic scan_done;   // search finished (hit or end)
    logic hit;         // search found its run
    logic commit_done; // last block written
  } sts_t;
endpackage

// ----- hdl/bba_ctrl.sv -----
`timescale 1ns / 1ps
module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bba_pkg::cmd_t cmd,
  input  bba_pkg::sts_t sts,
  output logic [1:0]    status_sel
);
  import bba_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] status, status_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign status_sel = status;

  always_comb begin
    state_next = state;
    status_next = status;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.is_free_op && sts.bad_size) begin
          status_next = ST_BAD_SIZE;
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.is_free_op) begin
            status_next = sts.hit ? ST_OK : ST_NOT_FOUND;
            state_next = S_DONE;
          end else if (sts.hit) begin
            status_next = ST_OK;
            state_next = S_COMMIT;
          end else begin
            status_next = ST_NO_SPACE;
            state_next = S_DONE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        if (sts.commit_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      status <= ST_OK;
    end else begin
      state <= state_next;
      status <= status_next;
    end
  end
endmodule

// ----- hdl/bba_datapath.sv -----
`timescale 1ns / 1ps
module bba_datapath (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_data,
  input  bba_pkg::req_t req,
  input  bba_pkg::cmd_t cmd,
  output bba_pkg::sts_t sts,
  output logic [7:0]    start_out
);
  import bba_pkg::*;

  logic [CW-1:0] num_blocks;
  logic [NBLK-1:0] free_map;
  logic [NBLK-1:0] owned;          // owner entry differs from own index
  logic [IW-1:0] owner_mem [NBLK]; // undefined where owned is clear
  logic [IW-1:0] owner_q;          // owner_mem[idx], registered from idx_next

  logic kind;
  logic [CW-1:0] len;
  logic [IW-1:0] target;
  logic [CW-1:0] idx;      // scan / commit position, may reach NBLK
  logic [CW-1:0] idx_next;
  logic [CW-1:0] run;
  logic [IW-1:0] start;
  logic hit, done;

  logic [CW-1:0] count;
  logic [IW-1:0] ii;
  logic [IW-1:0] own_i;
  logic at_end, match;

  assign count = (num_blocks > CW'(NBLK)) ? CW'(NBLK) : num_blocks;
  assign ii = idx[IW-1:0];
  assign own_i = owned[ii] ? owner_q : ii;
  assign at_end = (idx >= count);
  assign match = (own_i == target);

  assign sts.is_free_op = kind;
  assign sts.bad_size = (len == '0) || (len > count);
  assign sts.scan_done = done || at_end;
  assign sts.hit = hit;
  assign sts.commit_done = (idx == CW'(start) + len - CW'(1));
  assign start_out = start;

  always_comb begin
    idx_next = idx;
    if (cmd.load) begin
      idx_next = '0;
    end else if (cmd.step) begin
      if (kind == KIND_ALLOC) begin
        if (free_map[ii] && (run + CW'(1) == len)) idx_next = idx + CW'(1) - len;
        else idx_next = idx + CW'(1);
      end else if (match || !hit) begin
        idx_next = idx + CW'(1);
      end
    end else if (cmd.commit) begin
      idx_next = idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_blocks <= CW'(NBLK);
      free_map <= '1;
      owned <= '0;
      hit <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cfg_we) num_blocks <= cfg_data;
      idx <= idx_next;
      if (cmd.load) begin
        kind <= req.kind;
        len <= req.run_length;
        target <= req.block_index;
        run <= '0;
        start <= '0;
        hit <= 1'b0;
        done <= 1'b0;
      end else if (cmd.step) begin
        if (kind == KIND_ALLOC) begin
          if (free_map[ii]) begin
            if (run + CW'(1) == len) begin
              hit <= 1'b1;
              done <= 1'b1;
              start <= IW'(idx + CW'(1) - len);
            end
            run <= run + CW'(1);
          end else begin
            run <= '0;
          end
        end else begin
          if (match) begin
            hit <= 1'b1;
            owned[ii] <= 1'b0;
            free_map[ii] <= 1'b1;
          end else if (hit) begin
            done <= 1'b1;
          end
        end
      end else if (cmd.commit) begin
        free_map[ii] <= 1'b0;
        owned[ii] <= (start != ii);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) owner_mem[ii] <= start;
    owner_q <= owner_mem[idx_next[IW-1:0]];
  end
endmodule

// ----- hdl/bitmap_block_allocator.sv -----
`timescale 1ns / 1ps
// First-fit contiguous block allocator over a 256-block pool.
// req word (valid/ready): kind 0 allocates run_length blocks, kind 1 frees
// the first run owned by block_index. rsp word (valid/ready) carries status
// and start_block; one rsp word per req word.
// One request at a time: req is taken only when idle. An allocate scans one
// block per cycle up to the end of the run found (or the block count), then
// writes one block per cycle of the run. A free scans one block per cycle
// to the end of the owned run (or the block count). A bad size is answered
// from the check state, without a scan.
// The rsp word holds while rsp_ready is low; no new req is taken meanwhile.
// cfg_we writes num_blocks (0..511, used as at most 256) at once; write only while idle.
// Reset (rst, synchronous): all blocks free, every block owns itself,
// num_blocks = 256. No clearing pass is needed.
module bitmap_block_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_data,
  input  logic          req_valid,
  output logic          req_ready,
  input  bba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bba_pkg::rsp_t rsp
);
  import bba_pkg::*;
  `include "bitmap_block_allocator_assert.svh"

  cmd_t cmd;
  sts_t sts;
  logic [1:0] status_sel;
  logic [7:0] start_out;

  bba_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req_valid), .in_ready(req_ready),
    .out_valid(rsp_valid), .out_ready(rsp_ready),
    .cmd(cmd), .sts(sts), .status_sel(status_sel)
  );

  bba_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req), .cmd(cmd), .sts(sts), .start_out(start_out)
  );

  assign rsp.status = status_sel;
  assign rsp.start_block = (status_sel == ST_OK && !sts.is_free_op) ? start_out : '0;

  `BBA_ASSERT_IMPL(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd), "multiple commands")
  `BBA_ASSERT_IMPL(a_no_accept_busy, clk, rst, rsp_valid, !req_ready, "accept while busy")
  `BBA_ASSERT_NEXT(a_load_leaves_idle, clk, rst, cmd.load, !req_ready, "stayed idle")
endmodule

// ----- tb/bba_checker.sv -----
`timescale 1ns / 1ps
module bba_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [8:0]    cfg_data,
  input  logic          req_valid,
  input  logic          req_ready,
  input  bba_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  bba_pkg::rsp_t rsp,
  output int            errors,
  output int            pending
);
  import bba_pkg::*;

  logic [NBLK-1:0] free_bits;
  logic [IW-1:0]   owner [NBLK];
  logic [CW-1:0]   pool_size;
  rsp_t            awaited [$];

  function automatic rsp_t allocate_or_free(req_t r);
    rsp_t o;
    int   cnt;
    int   run;
    int   s;
    bit   hit;
    o = '{status: ST_OK, start_block: '0};
    cnt = (pool_size > NBLK) ? NBLK : pool_size;
    hit = 0;
    s = 0;
    run = 0;
    if (r.kind == KIND_ALLOC) begin
      if (r.run_length == 0 || r.run_length > cnt) begin
        o.status = ST_BAD_SIZE;
      end else begin
        for (int i = 0; i < cnt && !hit; i++) begin
          run = free_bits[i] ? run + 1 : 0;
          if (run == r.run_length) begin
            hit = 1;
            s = i + 1 - r.run_length;
          end
        end
        if (!hit) begin
          o.status = ST_NO_SPACE;
        end else begin
          for (int i = s; i < s + r.run_length; i++) begin
            free_bits[i] = 1'b0;
            owner[i] = s[IW-1:0];
          end
          o.start_block = s[IW-1:0];
        end
      end
    end else begin
      for (int i = 0; i < cnt; i++) begin
        if (owner[i] == r.block_index) begin
          hit = 1;
          owner[i] = i[IW-1:0];
          free_bits[i] = 1'b1;
        end else if (hit) begin
          break;
        end
      end
      if (!hit) o.status = ST_NOT_FOUND;
    end
    return o;
  endfunction

  assign pending = awaited.size();

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      free_bits = '1;
      for (int i = 0; i < NBLK; i++) owner[i] = i[IW-1:0];
      pool_size = 9'd256;
      awaited.delete();
      errors = 0;
    end else begin
      if (cfg_we) pool_size = cfg_data;
      if (rsp_valid && rsp_ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected word status=%0d start=%0d", $time, rsp.status,
                   rsp.start_block);
          errors++;
        end else begin
          e = awaited.pop_front();
          if (e.status !== rsp.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
          if (e.start_block !== rsp.start_block)
            $display("%0t: start_block expected %0d actual %0d", $time, e.start_block,
                     rsp.start_block);
          if (e !== rsp) errors++;
        end
      end
      if (req_valid && req_ready) awaited.push_back(allocate_or_free(req));
    end
  end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import bba_pkg::*;

  logic clk, rst, cfg_we, req_valid, req_ready, rsp_valid, rsp_ready;
  logic [8:0] cfg_data;
  req_t req;
  rsp_t rsp;
  int errors, pending, quiet, hold_off;
  int owned [$];

  bitmap_block_allocator dut (.*);
  bba_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with no word moving
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, occasionally long hold-offs
  initial begin
    rsp_ready = 0;
    hold_off = 0;
    @(negedge clk);
    while (1) begin
      @(negedge clk);
      if (hold_off > 0) begin
        rsp_ready <= 0;
        hold_off--;
      end else if ($urandom_range(0, 99) < 5) begin
        rsp_ready <= 0;
        hold_off = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      end else begin
        rsp_ready <= 1;
      end
    end
  end

  // ready only moves at posedge, so a high ready at negedge means accept at the next edge
  task automatic send(input logic k, input logic [8:0] len, input logic [7:0] idx);
    req_valid <= 1;
    req <= '{kind: k, run_length: len, block_index: idx};
    while (!req_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      req_valid <= 0;
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(negedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic set_pool(input int n);
    drain();
    cfg_we <= 1;
    cfg_data <= n[8:0];
    @(negedge clk);
    cfg_we <= 0;
    owned.delete();
  endtask

  task automatic random_mix(input int n, input int pool);
    int idx;
    for (int i = 0; i < n; i++) begin
      if (owned.size() > 0 && $urandom_range(0, 1)) begin
        idx = $urandom_range(0, owned.size() - 1);
        send(KIND_FREE, 9'($urandom), owned[idx][7:0]);
        owned.delete(idx);
      end else if ($urandom_range(0, 9) == 0) begin
        // noise: odd sizes and stray frees
        send(1'($urandom), 9'($urandom_range(0, 511)), 8'($urandom));
      end else begin
        send(KIND_ALLOC, 9'(($urandom_range(0, 7) == 0) ? $urandom_range(1, pool)
             : $urandom_range(1, (pool < 8) ? pool : 8)), 8'($urandom));
        if (chk.awaited.size() > 0 && chk.awaited[$].status == ST_OK)
          owned.push_back(int'(chk.awaited[$].start_block));
      end
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_data = 0;
    req_valid = 0;
    req = '0;
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed
    send(KIND_ALLOC, 0, 8'hff);
    send(KIND_ALLOC, 9'd257, 0);
    send(KIND_ALLOC, 9'd511, 0);
    send(KIND_FREE, 0, 8'd7);      // free of a block that owns itself
    send(KIND_ALLOC, 9'd256, 0);
    send(KIND_ALLOC, 1, 0);        // no space
    send(KIND_FREE, 9'h1ff, 0);
    send(KIND_ALLOC, 3, 8'h55);
    send(KIND_ALLOC, 5, 0);
    send(KIND_FREE, 0, 0);
    send(KIND_ALLOC, 2, 0);
    send(KIND_FREE, 0, 8'd3);
    send(KIND_FREE, 0, 8'd3);
    send(KIND_ALLOC, 1, 0);
    set_pool(1);
    send(KIND_ALLOC, 2, 0);
    send(KIND_ALLOC, 1, 0);
    send(KIND_FREE, 0, 8'd200);    // beyond shrunken pool: not found
    send(KIND_ALLOC, 1, 0);
    set_pool(0);
    send(KIND_ALLOC, 1, 0);
    send(KIND_FREE, 0, 0);
    set_pool(256);
    // long receiver hold-off while requests keep coming
    hold_off = 300;
    random_mix(10, 256);
    drain();
    random_mix(400, 256);
    set_pool(16);
    random_mix(300, 16);
    set_pool(100);
    random_mix(300, 100);
    set_pool(256);
    random_mix(260, 256);
    drain();
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ctrl.sv
hdl/bba_datapath.sv
hdl/bitmap_block_allocator.sv
tb/bba_checker.sv
tb/tb.sv
